>>> design/ewlc_pkg.sv
package ewlc_pkg;

    localparam int SetIndexBits = 6;
    localparam int Ways = 8;
    localparam int NumSets = 1 << SetIndexBits;
    localparam int WayBits = $clog2(Ways);
    localparam int TagBits = 64 - SetIndexBits;
    localparam int AgeBits = 4;
    localparam int LineBits = 1 + TagBits + AgeBits;
    localparam int RowBits = Ways * LineBits;
    localparam int QueueDepth = 2;
    localparam logic [AgeBits-1:0] AgeYoungest = AgeBits'(Ways);
    localparam logic [3:0] LineShiftReset = 4'd6;

    localparam logic OpAccess = 1'b0;
    localparam logic OpInvalidate = 1'b1;

    // One line of a set as kept in the row memory.
    typedef struct packed {
        logic valid;
        logic [TagBits-1:0] tag;
        logic [AgeBits-1:0] age;
    } t_line;

    // A classified command handed from the front end to the back end.
    typedef struct packed {
        logic invalidate;
        logic refill;
        logic [SetIndexBits-1:0] set;
        logic [TagBits-1:0] tag;
    } t_cmd;

    typedef enum logic [1:0] {
        t_back_clear,
        t_back_idle,
        t_back_read,
        t_back_update
    } t_back_state;

endpackage

>>> design/ewlc_if.sv
interface ewlc_in_if;
    logic valid;
    logic ready;
    logic op;
    logic [63:0] address;
    logic refill;
    modport source (output valid, op, address, refill, input ready);
    modport sink (input valid, op, address, refill, output ready);
endinterface

interface ewlc_out_if;
    logic valid;
    logic ready;
    logic hit;
    modport source (output valid, hit, input ready);
    modport sink (input valid, hit, output ready);
endinterface

>>> design/ewlc_ram.sv
module ewlc_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/ewlc_front.sv
module ewlc_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [3:0]            i_cfg_data,
    ewlc_in_if.sink               in_ch,
    output logic                  o_push,
    output ewlc_pkg::t_cmd        o_cmd,
    input  logic                  i_full
);
    import ewlc_pkg::*;

    logic [3:0]  r_line_shift;
    logic [63:0] line_index;

    // Line size register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_shift <= LineShiftReset;
        end else if (i_cfg_we) begin
            r_line_shift <= i_cfg_data;
        end
    end

    // Split the address into set and tag.
    assign line_index = in_ch.address >> r_line_shift;
    assign in_ch.ready = !i_full;
    assign o_push = in_ch.valid && !i_full;

    always_comb begin
        o_cmd.invalidate = (in_ch.op == OpInvalidate);
        o_cmd.refill = in_ch.refill;
        o_cmd.set = line_index[SetIndexBits-1:0];
        o_cmd.tag = line_index[63 -: TagBits];
    end

endmodule

>>> design/ewlc_queue.sv
module ewlc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ewlc_pkg::t_cmd i_cmd,
    output logic           o_full,
    output logic           o_empty,
    input  logic           i_pop,
    output ewlc_pkg::t_cmd o_cmd
);
    import ewlc_pkg::*;

    localparam int PtrBits = $clog2(QueueDepth);

    t_cmd               r_slot [QueueDepth];
    logic [PtrBits-1:0] r_wptr;
    logic [PtrBits-1:0] r_rptr;
    logic [PtrBits:0]   r_count;

    assign o_full = (r_count == (PtrBits+1)'(QueueDepth));
    assign o_empty = (r_count == '0);
    assign o_cmd = r_slot[r_rptr];

    // Pointers and fill count of the command queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Command storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

endmodule

>>> design/ewlc_back.sv
module ewlc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  ewlc_pkg::t_cmd i_cmd,
    output logic           o_pop,
    ewlc_out_if.source     out_ch,
    output logic           o_clearing
);
    import ewlc_pkg::*;

    t_back_state             r_state;
    t_back_state             n_state;
    logic [SetIndexBits-1:0] r_clr_idx;
    logic [SetIndexBits-1:0] n_clr_idx;
    t_cmd                    r_cmd;
    logic                    r_out_valid;
    logic                    r_out_hit;
    logic                    n_out_valid;
    logic                    n_out_hit;
    logic                    ram_we;
    logic [SetIndexBits-1:0] ram_waddr;
    logic [RowBits-1:0]      ram_wdata;
    logic [RowBits-1:0]      ram_rdata;
    t_line                   line_q [Ways];
    t_line                   line_d [Ways];
    logic [Ways-1:0]         match;
    logic                    hit_any;
    logic [WayBits-1:0]      hit_way;
    logic [WayBits-1:0]      victim;
    logic [WayBits-1:0]      chosen;
    logic                    do_update;
    logic [AgeBits:0]        best_key;
    logic [AgeBits:0]        ck;

    // The row of the latched command is read in the read state.
    ewlc_ram #(.Width(RowBits), .Depth(NumSets)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_cmd.set),
        .o_rdata (ram_rdata)
    );

    // Unpack the row and compare tags across the ways.
    always_comb begin
        hit_any = 1'b0;
        hit_way = '0;
        for (int w = 0; w < Ways; w++) begin
            line_q[w] = t_line'(ram_rdata[w*LineBits +: LineBits]);
            match[w] = line_q[w].valid && (line_q[w].tag == r_cmd.tag);
        end
        for (int w = Ways - 1; w >= 0; w--) begin
            if (match[w]) begin
                hit_any = 1'b1;
                hit_way = WayBits'(w);
            end
        end
    end

    // Victim is the oldest way, lowest number on a tie.
    always_comb begin
        victim = '0;
        best_key = {line_q[0].valid, line_q[0].age};
        for (int w = 1; w < Ways; w++) begin
            if ({line_q[w].valid, line_q[w].age} < best_key) begin
                victim = WayBits'(w);
                best_key = {line_q[w].valid, line_q[w].age};
            end
        end
    end

    // Make the chosen way youngest and age the younger ones.
    always_comb begin
        chosen = hit_any ? hit_way : victim;
        do_update = hit_any || r_cmd.refill;
        ck = {line_q[chosen].valid, line_q[chosen].age};
        for (int w = 0; w < Ways; w++) begin
            line_d[w] = line_q[w];
            if (WayBits'(w) == chosen) begin
                line_d[w].valid = 1'b1;
                line_d[w].tag = r_cmd.tag;
                line_d[w].age = AgeYoungest;
            end else if ({line_q[w].valid, line_q[w].age} > ck && line_q[w].age != '0) begin
                line_d[w].age = line_q[w].age - 1'b1;
            end
            ram_wdata[w*LineBits +: LineBits] = r_state == t_back_update
                ? line_d[w] : '0;
        end
    end

    // Sequencer: clearing sweep, command read, then update.
    always_comb begin
        n_state = r_state;
        n_clr_idx = r_clr_idx;
        n_out_valid = r_out_valid && !out_ch.ready;
        n_out_hit = r_out_hit;
        o_pop = 1'b0;
        ram_we = 1'b0;
        ram_waddr = r_clr_idx;
        case (r_state)
            t_back_clear: begin
                ram_we = 1'b1;
                n_clr_idx = r_clr_idx + 1'b1;
                if (r_clr_idx == SetIndexBits'(NumSets - 1)) begin
                    n_state = r_cmd.invalidate ? t_back_idle : t_back_idle;
                    if (r_cmd.invalidate && r_out_valid == 1'b0) begin
                        n_out_valid = 1'b1;
                        n_out_hit = 1'b0;
                    end
                end
            end
            t_back_idle: begin
                if (!i_empty && !n_out_valid) begin
                    o_pop = 1'b1;
                    n_state = i_cmd.invalidate ? t_back_clear : t_back_read;
                    n_clr_idx = '0;
                end
            end
            t_back_read: begin
                n_state = t_back_update;
            end
            t_back_update: begin
                ram_we = do_update;
                ram_waddr = r_cmd.set;
                n_out_valid = 1'b1;
                n_out_hit = hit_any;
                n_state = t_back_idle;
            end
            default: begin
                n_state = t_back_idle;
            end
        endcase
    end

    // State, sweep index, result valid and the latched command.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_back_clear;
            r_clr_idx <= '0;
            r_out_valid <= 1'b0;
            r_cmd.invalidate <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr_idx <= n_clr_idx;
            r_out_valid <= n_out_valid;
            if (o_pop) begin
                r_cmd.invalidate <= i_cmd.invalidate;
                r_cmd.refill <= i_cmd.refill;
                r_cmd.set <= i_cmd.set;
                r_cmd.tag <= i_cmd.tag;
            end
        end
    end

    // Result value.
    always_ff @(posedge i_clk) begin
        r_out_hit <= n_out_hit;
    end

    assign out_ch.valid = r_out_valid;
    assign out_ch.hit = r_out_hit;
    assign o_clearing = (r_state == t_back_clear);

endmodule

>>> design/eight_way_lru_cache_tag_model.sv
// Channel   Direction  Payload
// in_ch     sink       op, address[63:0], refill
// out_ch    source     hit
// cfg       write      i_cfg_we, i_cfg_data[3:0] (line_shift)
//
// An access in the back end goes through set row read, compare and
// write back, and result, in turn, over the single row memory port.
// An invalidate sweeps all 64 sets, one per cycle, before its result.
// After reset the same sweep clears the memory; commands queue meanwhile.
// The two-entry queue keeps accepting while a result is stalled, until full.
module eight_way_lru_cache_tag_model (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_data,
    ewlc_in_if.sink    in_ch,
    ewlc_out_if.source out_ch
);
    import ewlc_pkg::*;

    logic push;
    logic pop;
    logic full;
    logic empty;
    logic clearing;
    t_cmd front_cmd;
    t_cmd back_cmd;

    ewlc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .in_ch      (in_ch),
        .o_push     (push),
        .o_cmd      (front_cmd),
        .i_full     (full)
    );

    ewlc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .o_empty (empty),
        .i_pop   (pop),
        .o_cmd   (back_cmd)
    );

    ewlc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (empty),
        .i_cmd      (back_cmd),
        .o_pop      (pop),
        .out_ch     (out_ch),
        .o_clearing (clearing)
    );

    // No command leaves the queue during a clearing sweep.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) clearing |-> !pop)
        else $error("queue popped during clear sweep");

    // The queue never takes a transaction while full.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) full |-> !push)
        else $error("push into full queue");

    // A pending result holds while the sink stalls.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.hit))
        else $error("result dropped under stall");

endmodule

>>> test/tb_ewlc_pkg.sv
`timescale 1ns / 100ps
package tb_ewlc_pkg;

    import ewlc_pkg::*;

    // Cache tag shadow of every set and way.
    class lru_tag_shadow;
        logic                 valid [NumSets][Ways];
        logic [TagBits-1:0]   tag   [NumSets][Ways];
        logic [AgeBits-1:0]   age   [NumSets][Ways];
        logic [3:0]           line_shift;

        function void clear_lines();
            for (int s = 0; s < NumSets; s++) begin
                for (int w = 0; w < Ways; w++) begin
                    valid[s][w] = 1'b0;
                    tag[s][w] = '0;
                    age[s][w] = '0;
                end
            end
        endfunction

        function void reset_all();
            clear_lines();
            line_shift = LineShiftReset;
        endfunction

        // Validity ranks above age; a smaller key is older.
        function int unsigned rank(int s, int w);
            return 32'({valid[s][w], 4'b0, age[s][w]});
        endfunction

        function void promote(int s, int chosen, logic [TagBits-1:0] t);
            int unsigned ck;
            ck = rank(s, chosen);
            for (int w = 0; w < Ways; w++) begin
                if (w != chosen && rank(s, w) > ck && age[s][w] != 0) begin
                    age[s][w] = age[s][w] - 1'b1;
                end
            end
            valid[s][chosen] = 1'b1;
            tag[s][chosen] = t;
            age[s][chosen] = AgeYoungest;
        endfunction

        // Applies one command and returns the hit flag it produces.
        function logic apply(logic op, logic [63:0] address, logic refill);
            logic [63:0]        line_idx;
            int                 s;
            int                 victim;
            logic [TagBits-1:0] t;
            if (op == OpInvalidate) begin
                clear_lines();
                return 1'b0;
            end
            line_idx = address >> line_shift;
            s = int'(line_idx[SetIndexBits-1:0]);
            t = line_idx[63 -: TagBits];
            for (int w = 0; w < Ways; w++) begin
                if (valid[s][w] && tag[s][w] == t) begin
                    promote(s, w, t);
                    return 1'b1;
                end
            end
            if (refill) begin
                victim = 0;
                for (int w = 1; w < Ways; w++) begin
                    if (rank(s, w) < rank(s, victim)) begin
                        victim = w;
                    end
                end
                promote(s, victim, t);
            end
            return 1'b0;
        endfunction
    endclass

endpackage

>>> test/tb_eight_way_lru_cache_tag_model.sv
`timescale 1ns / 100ps
module tb_eight_way_lru_cache_tag_model;

    import ewlc_pkg::*;
    import tb_ewlc_pkg::*;

    localparam int CycleLimit = 400000;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [3:0] i_cfg_data;

    ewlc_in_if  in_ch ();
    ewlc_out_if out_ch ();

    eight_way_lru_cache_tag_model dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .in_ch      (in_ch.sink),
        .out_ch     (out_ch.source)
    );

    lru_tag_shadow cache_shadow;
    logic          expected_hits[$];
    int            failures;
    int            cycle_count;
    bit            hold_off;
    bit            random_stall;
    logic [63:0]   hot_addrs[$];

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog on the total run length.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= CycleLimit) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Result side: random stalls, plus a long hold-off when requested.
    initial begin
        int wait_cycles;
        out_ch.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_off) begin
                out_ch.ready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            wait_cycles = random_stall ? $urandom_range(0, 10) : 0;
            if (wait_cycles > 0) begin
                out_ch.ready <= 1'b0;
                repeat (wait_cycles) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!(out_ch.valid && out_ch.ready)) @(posedge i_clk);
        end
    end

    // Checks each accepted result transaction against the oldest expectation.
    initial begin
        logic want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                if (expected_hits.size() == 0) begin
                    $error("unexpected result transaction: hit=%0b", out_ch.hit);
                    failures++;
                end else begin
                    want = expected_hits.pop_front();
                    if (out_ch.hit !== want) begin
                        $error("hit mismatch: expected %0b, actual %0b", want, out_ch.hit);
                        failures++;
                    end
                end
            end
        end
    end

    // Sends one command transaction and records its predicted outcome.
    // Valid stays high after acceptance until the next command or a drain.
    task automatic send_cmd(logic op, logic [63:0] address, logic refill);
        int   gap;
        logic want;
        gap = random_stall ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.op <= op;
        in_ch.address <= address;
        in_ch.refill <= refill;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        want = cache_shadow.apply(op, address, refill);
        expected_hits = {expected_hits, want};
    endtask

    // Waits for all results, then lets an invalidate sweep settle.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_hits.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_line_shift(logic [3:0] value);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cache_shadow.line_shift = value;
    endtask

    // Builds an address for a chosen set and tag under the current shift.
    function automatic logic [63:0] make_addr(int s, logic [63:0] t);
        logic [63:0] line_idx;
        logic [63:0] low;
        line_idx = (t << SetIndexBits) | 64'(s);
        low = {$urandom, $urandom};
        low = low & ((64'd1 << cache_shadow.line_shift) - 1);
        return (line_idx << cache_shadow.line_shift) | low;
    endfunction

    // Extremes of the fields, both operations, misses without refill.
    task automatic test_directed();
        send_cmd(OpAccess, 64'h0, 1'b0);
        send_cmd(OpAccess, 64'h0, 1'b1);
        send_cmd(OpAccess, 64'h3f, 1'b0);
        send_cmd(OpAccess, 64'hffff_ffff_ffff_ffff, 1'b1);
        send_cmd(OpAccess, 64'hffff_ffff_ffff_ffff, 1'b0);
        send_cmd(OpAccess, 64'haaaa_aaaa_aaaa_aaaa, 1'b1);
        send_cmd(OpAccess, 64'h5555_5555_5555_5555, 1'b1);
        send_cmd(OpAccess, 64'haaaa_aaaa_aaaa_aaaa, 1'b0);
        send_cmd(OpInvalidate, 64'hffff_ffff_ffff_ffff, 1'b1);
        send_cmd(OpAccess, 64'h0, 1'b0);
        send_cmd(OpAccess, 64'hffff_ffff_ffff_ffff, 1'b0);
    endtask

    // Fills one set past capacity to exercise victim choice and aging.
    task automatic test_set_thrash(int s);
        for (int i = 0; i < 11; i++) begin
            send_cmd(OpAccess, make_addr(s, 64'(i)), 1'b1);
        end
        for (int i = 10; i >= 0; i--) begin
            send_cmd(OpAccess, make_addr(s, 64'(i)), 1'(i % 2));
        end
    endtask

    // Random traffic concentrated on a few sets and a small tag pool.
    task automatic test_random(int count);
        int          pick;
        logic [63:0] addr;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
                send_cmd(OpInvalidate, {$urandom, $urandom}, 1'($urandom));
            end else begin
                if (pick < 12 || hot_addrs.size() == 0) begin
                    addr = {$urandom, $urandom};
                end else if (pick < 55) begin
                    addr = hot_addrs[$urandom_range(0, hot_addrs.size() - 1)];
                end else begin
                    addr = make_addr($urandom_range(0, 3), 64'($urandom_range(0, 11)));
                end
                if (hot_addrs.size() < 40) hot_addrs = {hot_addrs, addr};
                send_cmd(OpAccess, addr, 1'($urandom_range(0, 3) != 0));
            end
        end
    endtask

    // Stalls the result side long enough for the block to back up.
    task automatic test_backpressure();
        hold_off = 1'b1;
        random_stall = 1'b0;
        for (int i = 0; i < 12; i++) begin
            send_cmd(OpAccess, make_addr(i % 3, 64'(i)), 1'b1);
        end
        random_stall = 1'b1;
    endtask

    initial begin
        cache_shadow = new();
        cache_shadow.reset_all();
        failures = 0;
        hold_off = 1'b0;
        random_stall = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = 4'd0;
        in_ch.valid = 1'b0;
        in_ch.op = OpAccess;
        in_ch.address = 64'h0;
        in_ch.refill = 1'b0;
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_set_thrash(5);
        random_stall = 1'b1;
        test_backpressure();
        test_random(110);
        write_line_shift(4'd0);
        test_set_thrash(63);
        test_random(110);
        write_line_shift(4'd15);
        test_directed();
        test_random(90);
        write_line_shift(4'd12);
        test_random(90);
        write_line_shift(4'd3);
        test_random(80);

        drain();
        if (failures == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
